FILE: rtl/aescbc_pkg.sv
// Package for the AES-128 CBC cipher unit: payload structs, register indexes,
// and the AES round functions (S-box, MixColumns, key schedule step).
package aescbc_pkg;

  localparam int BlockBits = 128;
  localparam int BlockBytes = 16;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  valid_bytes;
    logic        last_out;
  } out_item_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic [127:0] data;    // already padded (encrypt) or raw ciphertext
    logic         decrypt;
    logic         last;
    logic         extra;   // encrypt: a full pad block follows
  } job_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_MODE     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_DONE
  } core_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // Inverse S-box, by search over the forward table
  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit state; byte 0 in the top bits
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] = sbox(byte_at(s, r + 4*((c + r) & 3)));
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sbox(byte_at(s, r + 4*c));
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c); a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2); a3 = byte_at(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8]      = a0 ^ al ^ xt(a0 ^ a1);
      t[127 - 32*c - 8 -: 8]  = a1 ^ al ^ xt(a1 ^ a2);
      t[127 - 32*c - 16 -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      t[127 - 32*c - 24 -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    return t;
  endfunction

  // InvMixColumns as MixColumns after a pre-multiply step
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c); a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2); a3 = byte_at(s, 4*c+3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      t[127 - 32*c -: 8]      = a0 ^ u;
      t[127 - 32*c - 8 -: 8]  = a1 ^ v;
      t[127 - 32*c - 16 -: 8] = a2 ^ u;
      t[127 - 32*c - 24 -: 8] = a3 ^ v;
    end
    return mix(t);
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
      4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
      4'd9: v = 8'h1b; 4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/aes128_cbc_cipher_unit.sv
// AES-128 CBC cipher unit with PKCS#7 padding on encrypt and pad strip on
// decrypt. Items enter on the in channel (in_valid/in_stall/in_item), results
// leave on the out channel (out_valid/out_stall/out_item); a transfer happens
// at an edge where valid is high and stall is low.
// Each block runs one AES round per cycle in the core. Back to back the core
// takes the next job at the edge that loads a result; CBC chaining through the
// round loop sets the block rate. An encrypt last block of 16 bytes (or a
// count above 16) adds a second result, a full pad block, after the first.
// The front stage and a 2-entry job queue keep taking items while the core
// works; a stalled result holds in the output register and the core waits.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle;
// the unit does not enforce this. An IV write also loads the chain. After a key
// write the last-round key is walked forward through the schedule and the core
// takes no job until it is ready. Synchronous reset clears the configuration
// registers and the chain to zero; the zero-key walk resumes from a preset step.
module aes128_cbc_cipher_unit
  import aescbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [127:0] key, iv, last_key;
  logic mode, key_wr, key_busy;
  logic f_valid, f_take, q_valid, q_take;
  job_t f_job, q_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; iv <= '0; mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key[127:64] <= cfg_data;
        REG_KEY_LOW:  key[63:0] <= cfg_data;
        REG_IV_HIGH:  iv[127:64] <= cfg_data;
        REG_IV_LOW:   iv[63:0] <= cfg_data;
        REG_MODE:     mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) key_wr <= 1'b0;
    else key_wr <= cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  end

  aescbc_keys u_keys (.clk, .rst, .key_wr, .key, .last_key, .busy(key_busy));

  aescbc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item, .mode,
    .job_valid(f_valid), .job_take(f_take), .job(f_job)
  );

  aescbc_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_take(f_take), .wr_job(f_job),
    .rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job)
  );

  // Jobs wait in the queue while the last-round key is being prepared
  aescbc_core u_core (
    .clk, .rst, .job_valid(q_valid && !key_busy), .job_take(q_take), .job(q_job),
    .key, .last_key, .iv,
    .iv_hi_wr(cfg_we && cfg_index == REG_IV_HIGH),
    .iv_lo_wr(cfg_we && cfg_index == REG_IV_LOW),
    .cfg_data, .out_valid, .out_stall, .out_item
  );

endmodule

FILE: rtl/aescbc_front.sv
// Front end: accepts input blocks and classifies them into jobs (PKCS#7 pad).
// Depends on aescbc_pkg.
module aescbc_front
  import aescbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     mode,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job
);

  logic   full;
  job_t   cls;
  logic [4:0] cnt;
  logic [7:0] pad;

  // Pad bytes past the count on an encrypt last block
  always_comb begin
    cnt = (in_item.byte_count > 5'd16) ? 5'd16 : in_item.byte_count;
    pad = 8'(5'd16 - cnt);
    cls.data    = {in_item.block_high, in_item.block_low};
    cls.decrypt = mode;
    cls.last    = in_item.last_block;
    cls.extra   = !mode && in_item.last_block && (cnt == 5'd16);
    if (!mode && in_item.last_block) begin
      for (int i = 0; i < BlockBytes; i++)
        if (5'(i) >= cnt) cls.data[127 - 8*i -: 8] = pad;
    end
  end

  assign in_stall = full && !job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (job_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) job <= cls;
  end

  assign job_valid = full;

endmodule

FILE: rtl/aescbc_queue.sv
// Two-entry job queue between front end and cipher core.
// Depends on aescbc_pkg.
module aescbc_queue
  import aescbc_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_take,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_take,
  output job_t rd_job
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic wr, rd;

  assign wr_take  = wr_valid && (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign wr = wr_take;
  assign rd = rd_take && rd_valid;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_job;
  end

endmodule

FILE: rtl/aescbc_core.sv
// Cipher core: one AES round per cycle, CBC chain, pad strip, output register.
// Depends on aescbc_pkg.
module aescbc_core
  import aescbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_take,
  input  job_t         job,
  input  logic [127:0] key,
  input  logic [127:0] last_key,
  input  logic [127:0] iv,
  input  logic         iv_hi_wr,
  input  logic         iv_lo_wr,
  input  logic [63:0]  cfg_data,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_item
);

  core_state_t  state, state_next;
  logic [127:0] st, rk, chain, cipher_in;
  logic [3:0]   round;
  logic         dec, last, extra;
  logic [127:0] st_next, rk_next, fin;
  logic [127:0] rk_back, cipher_in_q, chain_new;
  logic         done;
  logic [7:0]   pb;
  out_item_t    res;

  // Round datapath
  always_comb begin
    rk_next = key_step(rk, rcon(round));
    if (!dec) begin
      st_next = sub_shift(st);
      if (round != 4'd10) st_next = mix(st_next);
      st_next = st_next ^ rk_next;
    end else begin
      st_next = inv_sub_shift(st) ^ rk_back;
      if (round != 4'd10) st_next = inv_mix(st_next);
    end
  end

  // Decrypt round keys come from the last round key walked backward
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96]; w1 = rk[95:64]; w2 = rk[63:32]; w3 = rk[31:0];
    w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
    t = {sbox(w3[23:16]) ^ rcon(4'd11 - round), sbox(w3[15:8]),
         sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    rk_back = {w0, w1, w2, w3};
  end

  assign done = (state == ST_ROUND) && (round == 4'd10);
  assign fin  = dec ? (st_next ^ chain) : st_next;
  assign pb   = fin[7:0];

  always_comb begin
    res.out_high    = fin[127:64];
    res.out_low     = fin[63:0];
    res.valid_bytes = 5'd16;
    res.last_out    = last && !extra;
    if (dec && last && pb >= 8'd1 && pb <= 8'd16) res.valid_bytes = 5'(8'd16 - pb);
  end

  logic can_out;
  assign can_out = !out_valid || !out_stall;

  // Sequencer
  always_comb begin
    state_next = state;
    job_take = 1'b0;
    unique case (state)
      ST_IDLE: if (job_valid) begin
        job_take = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: if (round == 4'd10 && can_out) begin
        if (extra) state_next = ST_PAD;
        else if (job_valid) begin
          job_take = 1'b1;
          state_next = ST_ROUND;
        end else state_next = ST_IDLE;
      end
      ST_PAD: state_next = ST_ROUND;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Chain after the finishing block; a job taken at that edge chains on it
  assign chain_new = (last && !extra) ? iv : (dec ? cipher_in_q : fin);
  assign cipher_in = job.decrypt ? job.data : job.data ^ (done ? chain_new : chain);

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
      chain <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (iv_hi_wr) chain[127:64] <= cfg_data;
      if (iv_lo_wr) chain[63:0] <= cfg_data;
      if (job_take) begin
        dec   <= job.decrypt;
        last  <= job.last;
        extra <= job.extra;
        cipher_in_q <= job.data;
        round <= 4'd1;
        st    <= job.decrypt ? (cipher_in ^ last_key) : (cipher_in ^ key);
        rk    <= job.decrypt ? last_key : key;
      end else if (state == ST_ROUND && round != 4'd10) begin
        round <= round + 4'd1;
        st    <= st_next;
        rk    <= dec ? rk_back : rk_next;
      end else if (state == ST_PAD) begin
        round <= 4'd1;
        extra <= 1'b0;
        st    <= {BlockBytes{8'h10}} ^ chain ^ key;
        rk    <= key;
      end
      if (done && can_out) begin
        out_valid <= 1'b1;
        out_item  <= res;
        chain     <= chain_new;
      end
    end
  end

  // Result never issued while the output register still holds a stalled one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output overwritten under stall");
  assert property (@(posedge clk) disable iff (rst)
    job_take |-> (state == ST_IDLE) || done)
    else $error("job taken mid block");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) |=> (state == ST_ROUND) && (round == 4'd1))
    else $error("pad block not started");

endmodule

FILE: rtl/aescbc_keys.sv
// Key register and last-round key precompute (one schedule step per cycle).
// Depends on aescbc_pkg.
module aescbc_keys
  import aescbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         key_wr,
  input  logic [127:0] key,
  output logic [127:0] last_key,
  output logic         busy
);

  logic [127:0] k;
  logic [3:0]   r;

  // Walks ten schedule steps after each key write
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= key_step(key_step(key_step(key_step(key_step('0, 8'h01), 8'h02),
           8'h04), 8'h08), 8'h10);
      r <= 4'd6;
    end else if (key_wr) begin
      r <= 4'd1;
    end else if (r == 4'd1) begin
      k <= key_step(key, rcon(4'd1));
      r <= 4'd2;
    end else if (r != 4'd11) begin
      k <= key_step(k, rcon(r));
      r <= r + 4'd1;
    end
  end

  assign last_key = k;
  // last_key is not valid until the walk reaches step ten
  assign busy = key_wr || (r != 4'd11);

endmodule

FILE: verif/tb_aes128_cbc_cipher_unit.sv
// Self-checking testbench for aes128_cbc_cipher_unit: AES-128 CBC with PKCS#7
// padding, checked against an in-bench block predictor over many key/IV/mode
// settings. Depends on rtl/aescbc_pkg.sv and rtl/aes128_cbc_cipher_unit.sv.
module tb_aes128_cbc_cipher_unit;
  import aescbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE = 3'd5;  // index past the register list
  localparam int NumPhases = 13;
  localparam int ItemsPerPhase = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes128_cbc_cipher_unit u_top (.*);

  always #4 clk = ~clk;

  // Cipher model state
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [127:0] aes_key, aes_iv, cbc_chain;
  logic         dec_mode;
  out_item_t    expected_blocks [$];
  int           fail_cnt = 0;
  bit           idle_bursts = 1'b1;
  int           hold_req = 0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  // S-box from the GF(2^8) inverse and the affine map
  initial begin
    logic [7:0] p, x;
    for (int a = 0; a < 256; a++) begin
      p = 8'h01;
      for (int k = 0; k < 254; k++) p = gmul(p, 8'(a));
      x = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]} ^ 8'h63;
      fwd_sb[a] = x;
      inv_sb[x] = 8'(a);
    end
  end

  function automatic void key_sched(input logic [127:0] key, output logic [127:0] rk [11]);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sb[t[23:16]] ^ rc, fwd_sb[t[15:8]], fwd_sb[t[7:0]], fwd_sb[t[31:24]]};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_fwd(input logic [127:0] key, input logic [127:0] s);
    logic [127:0] rk [11];
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    key_sched(key, rk);
    s ^= rk[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8*(r + 4*c) -: 8] = fwd_sb[get_b(s, r + 4*((c + r) & 3))];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
          a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
          t[127 - 32*c -: 32] = {gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3,
                                 a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3,
                                 a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3),
                                 gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2)};
        end
      end
      s = t ^ rk[rnd];
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_inv(input logic [127:0] key, input logic [127:0] s);
    logic [127:0] rk [11];
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    key_sched(key, rk);
    s ^= rk[10];
    for (int rnd = 9; rnd >= 0; rnd--) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sb[get_b(s, r + 4*c)];
      s = t ^ rk[rnd];
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
          a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
          s[127 - 32*c -: 32] = {
            gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9),
            gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13),
            gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11),
            gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14)};
        end
      end
    end
    return s;
  endfunction

  // Apply PKCS#7 fill to a last block with cnt leading data bytes
  function automatic logic [127:0] pkcs_fill(input logic [127:0] b, input int cnt);
    for (int i = cnt; i < 16; i++) b[127 - 8*i -: 8] = 8'(16 - cnt);
    return b;
  endfunction

  // Append one predicted result block to the expected queue
  function automatic void put_expected(input out_item_t r);
    expected_blocks.insert(expected_blocks.size(), r);
  endfunction

  // Predicts the result blocks of one accepted transfer; returns their number
  function automatic int cbc_predict(input in_item_t it);
    logic [127:0] b, p;
    int cnt;
    out_item_t r;
    cnt = (it.byte_count > 16) ? 16 : int'(it.byte_count);
    b = {it.block_high, it.block_low};
    if (!dec_mode) begin
      if (it.last_block && cnt < 16) b = pkcs_fill(b, cnt);
      if (!it.last_block) cnt = 16;
      cbc_chain = aes_fwd(aes_key, b ^ cbc_chain);
      r = '{cbc_chain[127:64], cbc_chain[63:0], 5'd16, it.last_block && cnt < 16};
      put_expected(r);
      if (it.last_block && cnt == 16) begin
        cbc_chain = aes_fwd(aes_key, {16{8'h10}} ^ cbc_chain);
        r = '{cbc_chain[127:64], cbc_chain[63:0], 5'd16, 1'b1};
        put_expected(r);
      end
    end else begin
      p = aes_inv(aes_key, b) ^ cbc_chain;
      cbc_chain = b;
      r = '{p[127:64], p[63:0], 5'd16, it.last_block};
      if (it.last_block && p[7:0] >= 8'd1 && p[7:0] <= 8'd16) r.valid_bytes = 5'(16 - p[7:0]);
      put_expected(r);
    end
    if (it.last_block) cbc_chain = aes_iv;
    return (!dec_mode && it.last_block && cnt == 16) ? 2 : 1;
  endfunction

  // Offer one item until it transfers, then predict it
  task automatic send_block(input in_item_t it, output int nres);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nres = cbc_predict(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_KEY_HIGH: aes_key[127:64] = d;
      REG_KEY_LOW:  aes_key[63:0] = d;
      REG_IV_HIGH:  begin aes_iv[127:64] = d; cbc_chain[127:64] = d; end
      REG_IV_LOW:   begin aes_iv[63:0] = d; cbc_chain[63:0] = d; end
      REG_MODE:     dec_mode = d[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t rand_item(input bit lst);
    in_item_t it;
    it.block_high = rand64();
    it.block_low  = rand64();
    it.byte_count = 5'($urandom_range(0, 31));
    it.last_block = lst;
    return it;
  endfunction

  // Directed rows at reset settings (zero key/IV, encrypt); -1 = use predictor
  typedef struct {
    in_item_t it;
    int       vb;
    int       lst;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{'{64'h0, 64'h0, 5'd16, 1'b1}, 16, 0},
    '{'{'1, '1, 5'd0, 1'b1}, 16, 1},
    '{'{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd1, 1'b1}, 16, 1},
    '{'{'1, 64'h0, 5'd15, 1'b1}, 16, 1},
    '{'{64'h0, '1, 5'd17, 1'b1}, 16, 0},
    '{'{'1, '1, 5'd31, 1'b1}, 16, 0},
    '{'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd5, 1'b0}, 16, 0},
    '{'{'1, '1, 5'd16, 1'b0}, 16, 0},
    '{'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd8, 1'b1}, 16, 1}
  };

  // Receiver: random stall bursts plus one long hold-off on request
  int stall_left = 0, hold_left = 0, hold_seen = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result transfer: %h", out_item);
      end else begin
        exp_r = expected_blocks.pop_front();
        if (out_item !== exp_r) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp %h_%h vb=%0d last=%0b got %h_%h vb=%0d last=%0b",
                     exp_r.out_high, exp_r.out_low, exp_r.valid_bytes, exp_r.last_out,
                     out_item.out_high, out_item.out_low, out_item.valid_bytes,
                     out_item.last_out);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int nres, sent, nb, cnt;
    logic [127:0] ch, pt;
    in_item_t it;
    in_item_t msg [$];
    aes_key = '0; aes_iv = '0; cbc_chain = '0; dec_mode = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_block(dir_rows[i].it, nres);
      if (dir_rows[i].vb >= 0)
        expected_blocks[expected_blocks.size() - nres].valid_bytes = 5'(dir_rows[i].vb);
      if (dir_rows[i].lst >= 0)
        expected_blocks[expected_blocks.size() - nres].last_out = dir_rows[i].lst[0];
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Drain, let the core settle, then reconfigure while idle
      in_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clk);
      repeat (40) @(posedge clk);
      if (ph == 0) begin
        write_reg(REG_KEY_HIGH, '1); write_reg(REG_KEY_LOW, '1);
        write_reg(REG_IV_HIGH, '1);  write_reg(REG_IV_LOW, '1);
        write_reg(REG_MODE, 64'd1);  write_reg(REG_SPARE, rand64());
      end else if (ph == 1) begin
        write_reg(REG_KEY_HIGH, '0); write_reg(REG_KEY_LOW, '0);
        write_reg(REG_IV_HIGH, '0);  write_reg(REG_IV_LOW, '0);
        write_reg(REG_MODE, 64'd0);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(REG_KEY_HIGH, rand64()); write_reg(REG_KEY_LOW, rand64());
        end
        if ($urandom_range(0, 3) != 0) begin
          write_reg(REG_IV_HIGH, rand64()); write_reg(REG_IV_LOW, rand64());
        end
        write_reg(REG_MODE, {rand64()} & 64'hffff_fffe | 64'(ph % 2));
      end
      cfg_we <= 1'b0;
      if (ph == NumPhases - 1) idle_bursts = 1'b0;
      if (ph == 3) hold_req++;

      sent = 0;
      while (sent < ItemsPerPhase) begin
        msg.delete();
        nb  = $urandom_range(1, 4);
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        if (dec_mode && $urandom_range(0, 4) != 0) begin
          // Well-formed ciphertext from a padded message under the same key and IV
          ch = cbc_chain;
          for (int k = 0; k < nb; k++) begin
            pt = {rand64(), rand64()};
            if (k == nb - 1) pt = pkcs_fill(pt, (cnt > 16) ? 16 : cnt);
            ch = aes_fwd(aes_key, pt ^ ch);
            it = rand_item(1'b0);
            {it.block_high, it.block_low} = ch;
            msg = {msg, it};
          end
          if (cnt >= 16) begin
            ch = aes_fwd(aes_key, {16{8'h10}} ^ ch);
            it = rand_item(1'b0);
            {it.block_high, it.block_low} = ch;
            msg = {msg, it};
          end
          msg[$].last_block = 1'b1;
        end else begin
          for (int k = 0; k < nb; k++) msg = {msg, rand_item(k == nb - 1)};
          msg[$].byte_count = 5'(cnt);
          // Now and then a message is cut short and runs on into the next one
          if ($urandom_range(0, 9) == 0) msg[$].last_block = 1'b0;
        end
        foreach (msg[k]) begin
          send_block(msg[k], nres);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && expected_blocks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
